### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every property is sampled on the
// rising edge of clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define SST_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define SST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set table package
// Shared types, operation codes and defaults for the sorted set table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sst_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic       was_member;
    logic [5:0] position;
    logic [6:0] count_after;
    logic       rejected;
  } rsp_t;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic               cmp_en;
    logic               ins_en;
    logic               rem_en;
    logic signed [31:0] key;
  } cell_ctrl_t;

endpackage

### hw/rtl/sst_cell.sv
// ----------------------------------------------------------------------------
// Sorted set table cell
// Holds one element, compares it against the broadcast key and shifts with
// its neighbors on insert and remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_cell (
  input  logic               clk,
  input  sst_pkg::cell_ctrl_t ctrl,
  input  logic               in_use,
  input  logic               left_lt,
  input  logic signed [31:0] left_val,
  input  logic signed [31:0] right_val,
  output logic               lt,
  output logic               eq,
  output logic signed [31:0] val
);
  import sst_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.cmp_en) begin
      lt <= in_use && (val < ctrl.key);
      eq <= in_use && (val == ctrl.key);
    end
    // Cells holding smaller elements keep them; the first cell at or above
    // the key takes the key on insert, the cells beyond it move up by one.
    if (ctrl.ins_en && !lt) begin
      val <= left_lt ? ctrl.key : left_val;
    end else if (ctrl.rem_en && !lt) begin
      val <= right_val;
    end
  end

endmodule

### hw/rtl/sst_slot_enc.sv
// ----------------------------------------------------------------------------
// Sorted set table slot encoder
// Turns the registered compare flags of the chain into the sorted slot of
// the key and its membership.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_slot_enc #(
  parameter int N  = sst_pkg::CAPACITY_DEF,
  parameter int CW = $clog2(N + 1)
) (
  input  logic [N-1:0]  lt,
  input  logic [N-1:0]  eq,
  output logic [CW-1:0] slot,
  output logic          present
);
  import sst_pkg::*;

  logic [N:0] bnd;

  // The less-than flags form a run from cell zero; the slot is the first
  // cell past that run, which may be one past the last cell.
  always_comb begin
    bnd[0] = !lt[0];
    for (int i = 1; i < N; i++) begin
      bnd[i] = lt[i-1] && !lt[i];
    end
    bnd[N] = lt[N-1];
  end

  always_comb begin
    slot = '0;
    for (int i = 0; i <= N; i++) begin
      if (bnd[i]) slot = slot | CW'(i);
    end
  end

  assign present = |eq;

endmodule

### hw/rtl/sorted_set_table.sv
// ----------------------------------------------------------------------------
// Sorted set table
// Set of distinct signed 32-bit values held in ascending order in a chain of
// cells, with insert, remove and membership query.
// ----------------------------------------------------------------------------
// Usage: a request (func, value) is transferred on req when req_valid is high
// and req_stall is low. Each request gives exactly one response on rsp,
// transferred when rsp_valid is high and rsp_stall is low.
// After the request transfers, every cell compares its element against the
// key and registers the result; then the slot is encoded, the chain shifts
// and the response is registered. A new request is taken only in the idle
// step, once the previous one has passed the registered compare step and
// the encode-and-shift step.
// The response register decouples the two sides: a request is accepted
// while the previous response still waits. When rsp_stall holds a response,
// the next request waits in its final step until the register frees.
// Reset empties the set at once (count zero); the cell contents are not
// cleared, as only cells below the count are ever compared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sorted_set_table #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  sst_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output sst_pkg::rsp_t rsp
);
  import sst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]         state;
  logic [1:0]         state_next;
  logic [1:0]         func;
  logic signed [31:0] key;
  logic [CW-1:0]      count;
  logic [CW-1:0]      count_next;

  cell_ctrl_t         ctrl;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic signed [31:0] val_arr [CAPACITY];

  logic [CW-1:0]      slot;
  logic               present;
  logic               full;
  logic               do_ins;
  logic               do_rem;
  logic               reject;
  logic               upd_go;
  logic               req_xfer;

  assign req_xfer  = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign upd_go    = (state == ST_UPD) && (!rsp_valid || !rsp_stall);

  assign full   = (count == CW'(CAPACITY));
  assign do_ins = (func == FUNC_INSERT) && !present && !full;
  assign do_rem = (func == FUNC_REMOVE) && present;
  assign reject = (func == FUNC_INSERT) && !present && full;

  always_comb begin
    count_next = count;
    if (do_ins) count_next = count + CW'(1);
    else if (do_rem) count_next = count - CW'(1);
  end

  always_comb begin
    ctrl.cmp_en = (state == ST_CMP);
    ctrl.ins_en = upd_go && do_ins;
    ctrl.rem_en = upd_go && do_rem;
    ctrl.key    = key;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (req_xfer) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (upd_go) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_go) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      func <= req.func;
      key  <= req.value;
    end
    if (upd_go) begin
      rsp.was_member  <= present;
      rsp.position    <= (present || do_ins) ? 6'(slot) : 6'd0;
      rsp.count_after <= 7'(count_next);
      rsp.rejected    <= reject;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic               left_lt;
    logic signed [31:0] left_val;
    logic signed [31:0] right_val;

    if (i == 0) begin : g_first
      assign left_lt  = 1'b1;
      assign left_val = key;
    end else begin : g_inner
      assign left_lt  = lt_vec[i-1];
      assign left_val = val_arr[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_val = val_arr[i];
    end else begin : g_body
      assign right_val = val_arr[i+1];
    end

    sst_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .in_use    (CW'(i) < count),
      .left_lt   (left_lt),
      .left_val  (left_val),
      .right_val (right_val),
      .lt        (lt_vec[i]),
      .eq        (eq_vec[i]),
      .val       (val_arr[i])
    );
  end

  sst_slot_enc #(
    .N  (CAPACITY),
    .CW (CW)
  ) u_enc (
    .lt      (lt_vec),
    .eq      (eq_vec),
    .slot    (slot),
    .present (present)
  );

  `SST_ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY), "element count exceeds capacity")
  `SST_ASSERT_SAME(a_reject_clean, rsp_valid && rsp.rejected,
    !rsp.was_member && rsp.position == 6'd0, "rejected insert reports membership or position")
  `SST_ASSERT_NEXT(a_req_to_cmp, req_xfer, state == ST_CMP, "request not followed by compare")
  `SST_ASSERT_NEXT(a_count_only_upd, !upd_go, $stable(count), "count changed outside update")

endmodule
